// ===== rtl/imuffp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package imuffp_pkg;

	// frame kinds, also the index of each kind's counter
	typedef logic [2:0] kind_t;
	localparam kind_t KIND_ACCEL   = 3'd0;
	localparam kind_t KIND_SKIP    = 3'd1;
	localparam kind_t KIND_TIME    = 3'd2;
	localparam kind_t KIND_SETTING = 3'd3;
	localparam kind_t KIND_DROP    = 3'd4;
	localparam kind_t KIND_UNKNOWN = 3'd5;
	localparam int unsigned NUM_KINDS = 6;

	// payload byte count of an open frame
	typedef logic [2:0] left_t;
	localparam int unsigned ACCEL_LEN = 6;

	// register indexes of the configuration port
	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_HEADER_MASK  = 3'd0;
	localparam reg_idx_t REG_ACCEL_CODE   = 3'd1;
	localparam reg_idx_t REG_SKIP_CODE    = 3'd2;
	localparam reg_idx_t REG_TIME_CODE    = 3'd3;
	localparam reg_idx_t REG_SETTING_CODE = 3'd4;
	localparam reg_idx_t REG_DROP_CODE    = 3'd5;

	// register reset values
	localparam logic [7:0] RST_HEADER_MASK  = 8'hFC;
	localparam logic [7:0] RST_ACCEL_CODE   = 8'h84;
	localparam logic [7:0] RST_SKIP_CODE    = 8'h40;
	localparam logic [7:0] RST_TIME_CODE    = 8'h44;
	localparam logic [7:0] RST_SETTING_CODE = 8'h48;
	localparam logic [7:0] RST_DROP_CODE    = 8'h50;

	typedef struct packed {
		logic [7:0] header_mask;
		logic [7:0] accel_code;
		logic [7:0] skip_code;
		logic [7:0] time_code;
		logic [7:0] setting_code;
		logic [7:0] drop_code;
	} cfg_regs_t;

	// payload length that follows each header
	function automatic left_t frame_len(input kind_t kind);
		left_t len;
		case (kind)
			KIND_ACCEL:   len = 3'd6;
			KIND_SKIP:    len = 3'd1;
			KIND_TIME:    len = 3'd3;
			KIND_SETTING: len = 3'd1;
			KIND_DROP:    len = 3'd1;
			default:      len = 3'd0;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/imuffp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// fifo byte channel
interface imuffp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] fifo_byte;
	logic       burst_last;

	modport source (output valid, output fifo_byte, output burst_last, input ready);
	modport sink (input valid, input fifo_byte, input burst_last, output ready);
endinterface

// parsed frame channel
interface imuffp_out_if;
	logic                valid;
	logic                ready;
	imuffp_pkg::kind_t   frame_kind;
	logic                sample_valid;
	logic signed [15:0]  accel_x;
	logic signed [15:0]  accel_y;
	logic signed [15:0]  accel_z;
	logic                truncated;
	logic [31:0]         kind_count;

	modport source (output valid, output frame_kind, output sample_valid, output accel_x,
		output accel_y, output accel_z, output truncated, output kind_count, input ready);
	modport sink (input valid, input frame_kind, input sample_valid, input accel_x,
		input accel_y, input accel_z, input truncated, input kind_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/imu_fifo_frame_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | dir | handshake     | word
// in_ch   | in  | valid/ready   | fifo_byte, burst_last
// out_ch  | out | valid/ready   | frame_kind, sample_valid, accel_x/y/z, truncated, kind_count
// cfg     | in  | cfg_wen only  | cfg_index, cfg_data (no read-back)
//
// one byte accepted per cycle while no stalled result holds the parser; the result word for the byte
// that ends a frame passes the input register, then parse logic into the output register
// the output register lets the next byte in while a result waits; a stalled result holds the
// parser only when the byte in the input register would produce another result
// arst_n clears counters, frame state, valid flags and config registers at once

module imu_fifo_frame_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wen,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [7:0]        cfg_data,
	imuffp_in_if.sink              in_ch,
	imuffp_out_if.source           out_ch
);

	imuffp_pkg::cfg_regs_t  cfg_q;

	logic                   vld_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;

	imuffp_pkg::kind_t      kind_q;
	imuffp_pkg::left_t      left_q;
	logic [7:0]             pay_q [imuffp_pkg::ACCEL_LEN];
	logic [31:0]            cnt_q [imuffp_pkg::NUM_KINDS];
	logic [31:0]            frame_cnt_q;

	logic                   out_vld_q;
	imuffp_pkg::kind_t      out_kind_q;
	logic                   out_sv_q;
	logic signed [15:0]     out_x_q;
	logic signed [15:0]     out_y_q;
	logic signed [15:0]     out_z_q;
	logic                   out_trunc_q;
	logic [31:0]            out_cnt_q;

	logic                   hdr_phase;
	logic [7:0]             masked;
	imuffp_pkg::kind_t      hdr_kind;
	logic [31:0]            cnt_inc;
	imuffp_pkg::left_t      pay_idx;
	imuffp_pkg::left_t      left_dec;
	logic                   emit;
	imuffp_pkg::kind_t      res_kind;
	logic                   res_sv;
	logic                   res_trunc;
	logic [31:0]            res_cnt;
	imuffp_pkg::left_t      nxt_left;
	imuffp_pkg::kind_t      nxt_kind;
	logic                   out_free;
	logic                   adv_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_mask  <= imuffp_pkg::RST_HEADER_MASK;
			cfg_q.accel_code   <= imuffp_pkg::RST_ACCEL_CODE;
			cfg_q.skip_code    <= imuffp_pkg::RST_SKIP_CODE;
			cfg_q.time_code    <= imuffp_pkg::RST_TIME_CODE;
			cfg_q.setting_code <= imuffp_pkg::RST_SETTING_CODE;
			cfg_q.drop_code    <= imuffp_pkg::RST_DROP_CODE;
		end else if (cfg_wen) begin
			case (cfg_index)
				imuffp_pkg::REG_HEADER_MASK:  cfg_q.header_mask  <= cfg_data;
				imuffp_pkg::REG_ACCEL_CODE:   cfg_q.accel_code   <= cfg_data;
				imuffp_pkg::REG_SKIP_CODE:    cfg_q.skip_code    <= cfg_data;
				imuffp_pkg::REG_TIME_CODE:    cfg_q.time_code    <= cfg_data;
				imuffp_pkg::REG_SETTING_CODE: cfg_q.setting_code <= cfg_data;
				imuffp_pkg::REG_DROP_CODE:    cfg_q.drop_code    <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	assign in_ch.ready = !vld_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			byte_s1 <= in_ch.fifo_byte;
			last_s1 <= in_ch.burst_last;
		end
	end

	// header match, first hit in kind order wins
	assign masked = byte_s1 & cfg_q.header_mask;

	always_comb begin
		if (masked == cfg_q.accel_code)
			hdr_kind = imuffp_pkg::KIND_ACCEL;
		else if (masked == cfg_q.skip_code)
			hdr_kind = imuffp_pkg::KIND_SKIP;
		else if (masked == cfg_q.time_code)
			hdr_kind = imuffp_pkg::KIND_TIME;
		else if (masked == cfg_q.setting_code)
			hdr_kind = imuffp_pkg::KIND_SETTING;
		else if (masked == cfg_q.drop_code)
			hdr_kind = imuffp_pkg::KIND_DROP;
		else
			hdr_kind = imuffp_pkg::KIND_UNKNOWN;
	end

	assign hdr_phase = (left_q == 3'd0);
	assign cnt_inc   = cnt_q[hdr_kind] + 32'd1;
	assign pay_idx   = imuffp_pkg::frame_len(kind_q) - left_q;
	assign left_dec  = left_q - 3'd1;

	// frame sequencing
	always_comb begin
		emit      = 1'b0;
		res_kind  = kind_q;
		res_sv    = 1'b0;
		res_trunc = 1'b0;
		res_cnt   = frame_cnt_q;
		nxt_kind  = kind_q;
		nxt_left  = left_dec;
		if (hdr_phase) begin
			nxt_kind = hdr_kind;
			res_kind = hdr_kind;
			res_cnt  = cnt_inc;
			nxt_left = imuffp_pkg::frame_len(hdr_kind);
			if (hdr_kind == imuffp_pkg::KIND_UNKNOWN) begin
				emit = 1'b1;
			end else if (last_s1) begin
				emit      = 1'b1;
				res_trunc = 1'b1;
				nxt_left  = 3'd0;
			end
		end else begin
			if (left_dec == 3'd0) begin
				emit   = 1'b1;
				res_sv = (kind_q == imuffp_pkg::KIND_ACCEL);
			end else if (last_s1) begin
				emit      = 1'b1;
				res_trunc = 1'b1;
				nxt_left  = 3'd0;
			end
		end
	end

	assign out_free = !out_vld_q || out_ch.ready;
	assign adv_s1   = vld_s1 && (!emit || out_free);

	// frame state and kind counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= imuffp_pkg::KIND_ACCEL;
			left_q <= 3'd0;
			for (int i = 0; i < imuffp_pkg::NUM_KINDS; i++)
				cnt_q[i] <= 32'd0;
		end else if (adv_s1) begin
			kind_q <= nxt_kind;
			left_q <= nxt_left;
			if (hdr_phase)
				cnt_q[hdr_kind] <= cnt_inc;
		end
	end

	// payload bytes and the open frame's count
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			if (hdr_phase)
				frame_cnt_q <= cnt_inc;
			else if (pay_idx < 3'(imuffp_pkg::ACCEL_LEN))
				pay_q[pay_idx] <= byte_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1 && emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit) begin
			out_kind_q  <= res_kind;
			out_sv_q    <= res_sv;
			out_trunc_q <= res_trunc;
			out_cnt_q   <= res_cnt;
			if (res_sv) begin
				out_x_q <= {pay_q[1], pay_q[0]};
				out_y_q <= {pay_q[3], pay_q[2]};
				out_z_q <= {byte_s1, pay_q[4]};
			end else begin
				out_x_q <= 16'sd0;
				out_y_q <= 16'sd0;
				out_z_q <= 16'sd0;
			end
		end
	end

	assign out_ch.valid        = out_vld_q;
	assign out_ch.frame_kind   = out_kind_q;
	assign out_ch.sample_valid = out_sv_q;
	assign out_ch.accel_x      = out_x_q;
	assign out_ch.accel_y      = out_y_q;
	assign out_ch.accel_z      = out_z_q;
	assign out_ch.truncated    = out_trunc_q;
	assign out_ch.kind_count   = out_cnt_q;

	// checks
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= 3'(imuffp_pkg::ACCEL_LEN))
		else $error("payload count out of range");

	a_sample_accel: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_sv_q |-> out_kind_q == imuffp_pkg::KIND_ACCEL && !out_trunc_q)
		else $error("sample marked valid on a non-accel or truncated frame");

	a_unknown_whole: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_kind_q == imuffp_pkg::KIND_UNKNOWN |-> !out_trunc_q && !out_sv_q)
		else $error("unknown frame flagged truncated or valid");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && emit |=> out_vld_q)
		else $error("result lost on its way to the output register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_ch.ready |-> !(adv_s1 && emit))
		else $error("pending result overwritten");

endmodule

`default_nettype wire
